// ----- hw/rtl/joint_angle_stroke_table_converter_assert.svh -----
// ============================================================================
// Assertion macros for the joint angle / stroke table converter
// Concurrent assertion shorthands used by the converter RTL, which checks
// itself: an overlapping implication and a next-cycle implication.
// ============================================================================
`ifndef JOINT_ANGLE_STROKE_TABLE_CONVERTER_ASSERT_SVH
`define JOINT_ANGLE_STROKE_TABLE_CONVERTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JASTC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JASTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/jastc_pkg.sv -----
// ============================================================================
// Joint angle / stroke table converter package
// Field widths, word layout, codes and shared types of the converter.
// ============================================================================
`default_nettype none

package jastc_pkg;

   localparam int NUM_TABLES_DEF = 16;
   localparam int MAX_ROWS_DEF   = 256;

   // Field widths.
   localparam int FUNC_W      = 2;
   localparam int TABLE_ID_W  = 4;
   localparam int ROW_INDEX_W = 8;
   localparam int ANGLE_W     = 9;
   localparam int STROKE_W    = 16;
   localparam int QUERY_W     = 16;
   localparam int VALUE_W     = 16;
   localparam int STATUS_W    = 2;

   // Request data word layout, lowest field first.
   localparam int TID_LSB      = 0;
   localparam int RI_LSB       = TID_LSB + TABLE_ID_W;
   localparam int ANG_LSB      = RI_LSB + ROW_INDEX_W;
   localparam int STK_LSB      = ANG_LSB + ANGLE_W;
   localparam int QRY_LSB      = STK_LSB + STROKE_W;
   localparam int REQ_FIELDS_W = QRY_LSB + QUERY_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W   = ((VALUE_W + 7) / 8) * 8;

   // One stored row: angle above stroke.
   localparam int ROW_DATA_W = ANGLE_W + STROKE_W;

   // Datapath widths.
   localparam int KEY_W  = 17;
   localparam int DIFF_W = KEY_W + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int RES_W  = PROD_W + 1;

   // Divider: quotient bits retired per cycle.
   localparam int DIV_STEPS  = 3;
   localparam int DIV_CYCLES = PROD_W / DIV_STEPS;

   localparam logic signed [KEY_W-1:0]  CENTI_KEY  = 100;
   localparam logic signed [DIFF_W-1:0] CENTI_DIFF = 100;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD = 2'd0,
      FUNC_FWD  = 2'd1,
      FUNC_INV  = 2'd2,
      FUNC_NONE = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_SHORT     = 2'd1,
      STATUS_ZERO_STEP = 2'd2,
      STATUS_SATURATED = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FALL_RD,
      ST_FALL_CMP,
      ST_RD_LO,
      ST_RD_HI,
      ST_CLAMP,
      ST_SRCH,
      ST_SRCH_CMP,
      ST_RD_J,
      ST_RD_P,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_FIN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

`default_nettype wire

// ----- hw/rtl/joint_angle_stroke_table_converter.sv -----
// ============================================================================
// Joint angle / stroke table converter
// Calibration tables of (degree, stroke) rows in one row RAM; queries clamp,
// binary-search and interpolate between two rows in either direction.
// ============================================================================
//
//   Channel  Dir  Handshake              Contents
//   req      in   req_tvalid/req_tready  func on tuser, last_row on tlast,
//                                        table, row and query fields on tdata
//   rsp      out  rsp_tvalid/rsp_tready  result_value on tdata, status on tuser
//
// A row load writes the RAM as it is accepted; a load of row 0 or 1 also
// reads the other of those rows (the stroke direction of the table is
// refreshed from the RAM). A query clamps, binary-searches with one RAM
// read per search probe, multiplies and divides; the divider retires three
// quotient bits per cycle. One word is in work at a time.
// Reset is synchronous and clears the table lengths, stroke directions and
// the control state; the row RAM holds no reset value.
// A finished word waits in the output register while the next request is
// accepted; a stalled rsp side only holds back the final write of that word.
//
`default_nettype none

`include "joint_angle_stroke_table_converter_assert.svh"

module joint_angle_stroke_table_converter #(
   parameter int NUM_TABLES = jastc_pkg::NUM_TABLES_DEF,
   parameter int MAX_ROWS   = jastc_pkg::MAX_ROWS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // tdata from bit 0: table_id, row_index, row_angle, row_stroke, query_value,
   // then zero padding.
   input  logic [jastc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: func.
   input  logic [jastc_pkg::FUNC_W-1:0]         req_tuser,
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // tdata: result_value.
   output logic [jastc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // tuser: status.
   output logic [jastc_pkg::STATUS_W-1:0]       rsp_tuser
);

   localparam int DEPTH  = NUM_TABLES * MAX_ROWS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int TID_W  = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int LEN_W  = $clog2(MAX_ROWS + 1);
   localparam int SUM_W  = LEN_W + 1;

   localparam int KEY_W  = jastc_pkg::KEY_W;
   localparam int DIFF_W = jastc_pkg::DIFF_W;
   localparam int PROD_W = jastc_pkg::PROD_W;
   localparam int RES_W  = jastc_pkg::RES_W;
   localparam int VAL_W  = jastc_pkg::VALUE_W;
   localparam int STK_W  = jastc_pkg::STROKE_W;
   localparam int RSP_W  = jastc_pkg::RSP_DATA_W;

   localparam logic signed [RES_W-1:0] RES_MAX = 32767;
   localparam logic signed [RES_W-1:0] RES_MIN = -32768;

   // Search key of a row: centidegrees going forward, stroke going back.
   function automatic logic signed [KEY_W-1:0] key_of(
      input logic [jastc_pkg::ROW_DATA_W-1:0] d,
      input logic                             inv
   );
      logic signed [KEY_W-1:0] ang;
      logic signed [KEY_W-1:0] stk;
      ang = KEY_W'($signed(d[jastc_pkg::ROW_DATA_W-1:STK_W]));
      stk = KEY_W'($signed(d[STK_W-1:0]));
      key_of = inv ? stk : ang * jastc_pkg::CENTI_KEY;
   endfunction

   // The interpolated quantity of a row in the same direction.
   function automatic logic signed [KEY_W-1:0] oth_of(
      input logic [jastc_pkg::ROW_DATA_W-1:0] d,
      input logic                             inv
   );
      oth_of = key_of(d, !inv);
   endfunction

   // ------------------------------------------------------------------------
   // Request fields
   // ------------------------------------------------------------------------
   jastc_pkg::func_type                 func_req;
   logic [jastc_pkg::TABLE_ID_W-1:0]    tid_req;
   logic [jastc_pkg::ROW_INDEX_W-1:0]   ri_req;
   logic [jastc_pkg::ANGLE_W-1:0]       ang_req;
   logic signed [STK_W-1:0]             stk_req;
   logic signed [jastc_pkg::QUERY_W-1:0] qry_req;

   assign func_req = jastc_pkg::func_type'(req_tuser);
   assign tid_req  = req_tdata[jastc_pkg::TID_LSB +: jastc_pkg::TABLE_ID_W];
   assign ri_req   = req_tdata[jastc_pkg::RI_LSB  +: jastc_pkg::ROW_INDEX_W];
   assign ang_req  = req_tdata[jastc_pkg::ANG_LSB +: jastc_pkg::ANGLE_W];
   assign stk_req  = req_tdata[jastc_pkg::STK_LSB +: STK_W];
   assign qry_req  = req_tdata[jastc_pkg::QRY_LSB +: jastc_pkg::QUERY_W];

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   jastc_pkg::state_type   state_ff, state_in;
   logic [LEN_W-1:0]       len_ff  [NUM_TABLES];
   logic                   fall_ff [NUM_TABLES];
   logic                   rsp_tvalid_ff;

   logic [TID_W-1:0]       tsel_ff;
   logic [ADDR_W-1:0]      base_ff;
   logic [ROW_W-1:0]       ri_ff;
   logic signed [STK_W-1:0] stroke_ff;
   logic signed [KEY_W-1:0] q_ff;
   logic [LEN_W-1:0]       n_ff;
   logic                   inv_ff;
   logic                   rev_ff;
   logic [ROW_W-1:0]       first_ff;
   logic [ROW_W-1:0]       count_ff;
   logic signed [KEY_W-1:0] lo_ff;
   logic signed [KEY_W-1:0] kj_ff;
   logic signed [KEY_W-1:0] oj_ff;
   logic signed [DIFF_W-1:0] a_ff;
   logic signed [DIFF_W-1:0] b_ff;
   logic signed [DIFF_W-1:0] dvs_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [VAL_W-1:0] res_ff;
   jastc_pkg::status_type  status_ff;
   logic signed [VAL_W-1:0] rsp_value_ff;
   jastc_pkg::status_type  rsp_status_ff;

   // ------------------------------------------------------------------------
   // Request decode
   // ------------------------------------------------------------------------
   logic              req_fire;
   logic              t_ok;
   logic              ri_ok;
   logic [TID_W-1:0]  tsel_req;
   logic [ROW_W-1:0]  row_req;
   logic [ADDR_W-1:0] base_req;
   logic [LEN_W-1:0]  n_req;
   logic              fall_req;
   logic              load_ok;

   assign req_fire = req_tvalid && req_tready;
   assign t_ok     = (int'(tid_req) < NUM_TABLES);
   assign ri_ok    = (int'(ri_req) < MAX_ROWS);
   assign tsel_req = TID_W'(tid_req);
   assign row_req  = ROW_W'(ri_req);
   assign base_req = ADDR_W'(tsel_req) * ADDR_W'(MAX_ROWS);
   assign n_req    = t_ok ? len_ff[tsel_req] : '0;
   assign fall_req = t_ok ? fall_ff[tsel_req] : 1'b0;
   assign load_ok  = (func_req == jastc_pkg::FUNC_LOAD) && t_ok && ri_ok;

   // ------------------------------------------------------------------------
   // Search bookkeeping and row RAM
   // ------------------------------------------------------------------------
   logic [ROW_W-1:0]  half;
   logic [ROW_W-1:0]  mid;
   logic [ROW_W-1:0]  rd_row;
   logic              rd_by_key;
   logic [ROW_W-1:0]  rd_phys;
   logic              ram_we;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [jastc_pkg::ROW_DATA_W-1:0] ram_wr_data;
   logic [jastc_pkg::ROW_DATA_W-1:0] ram_rd_data;

   assign half = count_ff >> 1;
   assign mid  = first_ff + half;

   // Rows are addressed in key order; a falling table is walked backward
   // when searching by stroke.
   always_comb begin
      if (!rd_by_key) begin
         rd_phys = (ri_ff == '0) ? ROW_W'(1) : '0;
      end else if (rev_ff) begin
         rd_phys = ROW_W'(n_ff - LEN_W'(1)) - rd_row;
      end else begin
         rd_phys = rd_row;
      end
   end

   assign ram_wr_addr = base_req + ADDR_W'(row_req);
   assign ram_wr_data = {ang_req, stk_req};
   assign ram_rd_addr = base_ff + ADDR_W'(rd_phys);

   jastc_ram #(
      .WIDTH (jastc_pkg::ROW_DATA_W),
      .DEPTH (DEPTH)
   ) u_rows (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_re),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------------
   // Divider
   // ------------------------------------------------------------------------
   jastc_pkg::div_ctl_type  div_ctl;
   jastc_pkg::div_sts_type  div_sts;
   logic signed [PROD_W-1:0] quot;

   jastc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (prod_ff),
      .divisor  (dvs_ff),
      .quotient (quot),
      .sts      (div_sts)
   );

   // ------------------------------------------------------------------------
   // Datapath helpers
   // ------------------------------------------------------------------------
   logic signed [KEY_W-1:0]  rd_key;
   logic signed [KEY_W-1:0]  rd_oth;
   logic signed [KEY_W-1:0]  q_clamp;
   logic signed [DIFF_W-1:0] step_v;
   logic                     zero_step;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [RES_W-1:0]  res_full;
   logic                     out_load;

   assign rd_key = key_of(ram_rd_data, inv_ff);
   assign rd_oth = oth_of(ram_rd_data, inv_ff);

   // Clamp to the first row, then to the last one, in that order.
   always_comb begin
      q_clamp = (q_ff < lo_ff) ? lo_ff : q_ff;
      if (q_clamp > rd_key) begin
         q_clamp = rd_key;
      end
   end

   always_comb begin
      step_v = DIFF_W'(kj_ff) - DIFF_W'(rd_key);
      if (rev_ff) begin
         step_v = -step_v;
      end
   end

   assign zero_step = inv_ff && (step_v == '0);
   assign prod_in   = a_ff * b_ff;
   assign res_full  = RES_W'(oj_ff) - RES_W'(quot);

   // ------------------------------------------------------------------------
   // Sequencer: next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         jastc_pkg::ST_IDLE: begin
            if (req_fire) begin
               priority if (func_req == jastc_pkg::FUNC_LOAD) begin
                  state_in = (load_ok && (ri_req < 2)) ? jastc_pkg::ST_FALL_RD
                                                       : jastc_pkg::ST_RESP;
               end else if (func_req == jastc_pkg::FUNC_FWD ||
                            func_req == jastc_pkg::FUNC_INV) begin
                  state_in = (n_req < LEN_W'(2)) ? jastc_pkg::ST_RESP
                                                 : jastc_pkg::ST_RD_LO;
               end else begin
                  state_in = jastc_pkg::ST_RESP;
               end
            end
         end
         jastc_pkg::ST_FALL_RD:  state_in = jastc_pkg::ST_FALL_CMP;
         jastc_pkg::ST_FALL_CMP: state_in = jastc_pkg::ST_RESP;
         jastc_pkg::ST_RD_LO:    state_in = jastc_pkg::ST_RD_HI;
         jastc_pkg::ST_RD_HI:    state_in = jastc_pkg::ST_CLAMP;
         jastc_pkg::ST_CLAMP:    state_in = jastc_pkg::ST_SRCH;
         jastc_pkg::ST_SRCH: begin
            state_in = (count_ff == '0) ? jastc_pkg::ST_RD_J : jastc_pkg::ST_SRCH_CMP;
         end
         jastc_pkg::ST_SRCH_CMP: state_in = jastc_pkg::ST_SRCH;
         jastc_pkg::ST_RD_J:     state_in = jastc_pkg::ST_RD_P;
         jastc_pkg::ST_RD_P: begin
            state_in = zero_step ? jastc_pkg::ST_RESP : jastc_pkg::ST_MUL;
         end
         jastc_pkg::ST_MUL:      state_in = jastc_pkg::ST_DIV_GO;
         jastc_pkg::ST_DIV_GO:   state_in = jastc_pkg::ST_DIV_WAIT;
         jastc_pkg::ST_DIV_WAIT: begin
            if (div_sts.done) begin
               state_in = jastc_pkg::ST_FIN;
            end
         end
         jastc_pkg::ST_FIN:      state_in = jastc_pkg::ST_RESP;
         jastc_pkg::ST_RESP: begin
            if (out_load) begin
               state_in = jastc_pkg::ST_IDLE;
            end
         end
         default:                state_in = jastc_pkg::ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------
   // Sequencer: outputs
   // ------------------------------------------------------------------------
   always_comb begin
      req_tready    = 1'b0;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      rd_row        = '0;
      rd_by_key     = 1'b1;
      div_ctl.start = 1'b0;
      out_load      = 1'b0;
      unique case (state_ff)
         jastc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            ram_we     = req_tvalid && load_ok;
         end
         jastc_pkg::ST_FALL_RD: begin
            ram_re    = 1'b1;
            rd_by_key = 1'b0;
         end
         jastc_pkg::ST_RD_LO: begin
            ram_re = 1'b1;
         end
         jastc_pkg::ST_RD_HI: begin
            ram_re = 1'b1;
            rd_row = ROW_W'(n_ff - LEN_W'(1));
         end
         jastc_pkg::ST_SRCH: begin
            ram_re = 1'b1;
            rd_row = (count_ff == '0) ? first_ff : mid;
         end
         jastc_pkg::ST_RD_J: begin
            ram_re = 1'b1;
            rd_row = first_ff - ROW_W'(1);
         end
         jastc_pkg::ST_DIV_GO: begin
            div_ctl.start = 1'b1;
         end
         jastc_pkg::ST_RESP: begin
            out_load = !rsp_tvalid_ff || rsp_tready;
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= jastc_pkg::ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
         for (int i = 0; i < NUM_TABLES; i++) begin
            len_ff[i]  <= '0;
            fall_ff[i] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         if (req_fire && load_ok && req_tlast) begin
            len_ff[tsel_req] <= LEN_W'(ri_req) + LEN_W'(1);
         end
         // The table falls when the stroke of row 1 is below that of row 0.
         if (state_ff == jastc_pkg::ST_FALL_CMP) begin
            fall_ff[tsel_ff] <= (ri_ff == '0)
                                ? ($signed(ram_rd_data[STK_W-1:0]) < stroke_ff)
                                : (stroke_ff < $signed(ram_rd_data[STK_W-1:0]));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Payload registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_fire) begin
         tsel_ff   <= tsel_req;
         base_ff   <= base_req;
         ri_ff     <= row_req;
         stroke_ff <= stk_req;
         q_ff      <= KEY_W'(qry_req);
         n_ff      <= n_req;
         inv_ff    <= (func_req == jastc_pkg::FUNC_INV);
         rev_ff    <= (func_req == jastc_pkg::FUNC_INV) && fall_req;
         first_ff  <= ROW_W'(1);
         count_ff  <= ROW_W'(n_req - LEN_W'(2));
         res_ff    <= '0;
         status_ff <= ((func_req == jastc_pkg::FUNC_FWD || func_req == jastc_pkg::FUNC_INV) &&
                       (n_req < LEN_W'(2))) ? jastc_pkg::STATUS_SHORT : jastc_pkg::STATUS_OK;
      end

      unique case (state_ff)
         jastc_pkg::ST_RD_HI: begin
            lo_ff <= rd_key;
         end
         jastc_pkg::ST_CLAMP: begin
            q_ff <= q_clamp;
         end
         jastc_pkg::ST_SRCH_CMP: begin
            if (q_ff >= rd_key) begin
               first_ff <= mid + ROW_W'(1);
               count_ff <= count_ff - half - ROW_W'(1);
            end else begin
               count_ff <= half;
            end
         end
         jastc_pkg::ST_RD_J: begin
            kj_ff <= rd_key;
            oj_ff <= rd_oth;
            a_ff  <= DIFF_W'(rd_key) - DIFF_W'(q_ff);
         end
         jastc_pkg::ST_RD_P: begin
            b_ff   <= inv_ff ? jastc_pkg::CENTI_DIFF : DIFF_W'(oj_ff) - DIFF_W'(rd_oth);
            dvs_ff <= inv_ff ? step_v : jastc_pkg::CENTI_DIFF;
            if (zero_step) begin
               status_ff <= jastc_pkg::STATUS_ZERO_STEP;
            end
         end
         jastc_pkg::ST_MUL: begin
            prod_ff <= prod_in;
         end
         jastc_pkg::ST_FIN: begin
            priority if (res_full > RES_MAX) begin
               res_ff    <= VAL_W'(RES_MAX);
               status_ff <= jastc_pkg::STATUS_SATURATED;
            end else if (res_full < RES_MIN) begin
               res_ff    <= VAL_W'(RES_MIN);
               status_ff <= jastc_pkg::STATUS_SATURATED;
            end else begin
               res_ff <= res_full[VAL_W-1:0];
            end
         end
         default: begin
         end
      endcase

      if (out_load) begin
         rsp_value_ff  <= res_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_W'(rsp_value_ff);
   assign rsp_tuser  = rsp_status_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `JASTC_ASSERT_IMPL(a_div_start_free, clock, reset, div_ctl.start, !div_sts.busy,
                      "divider started while still busy")
   `JASTC_ASSERT_NEXT(a_resp_waits, clock, reset,
                      (state_ff == jastc_pkg::ST_RESP) && rsp_tvalid_ff && !rsp_tready,
                      state_ff == jastc_pkg::ST_RESP,
                      "result left before the waiting word was taken")
   `JASTC_ASSERT_IMPL(a_zero_step_value, clock, reset,
                      rsp_tvalid_ff && (rsp_status_ff == jastc_pkg::STATUS_ZERO_STEP),
                      rsp_value_ff == '0,
                      "zero step word carries a nonzero value")
   `JASTC_ASSERT_IMPL(a_search_bound, clock, reset,
                      state_ff == jastc_pkg::ST_SRCH,
                      (SUM_W'(first_ff) + SUM_W'(count_ff)) < SUM_W'(n_ff),
                      "search window runs past the last row")

endmodule

`default_nettype wire

// ----- hw/rtl/jastc_ram.sv -----
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port, with registered read data.
// ============================================================================
`default_nettype none

module jastc_ram #(
   parameter int  WIDTH  = jastc_pkg::ROW_DATA_W,
   parameter int  DEPTH  = jastc_pkg::NUM_TABLES_DEF * jastc_pkg::MAX_ROWS_DEF,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/jastc_div.sv -----
// ============================================================================
// Iterative signed divider
// Restoring division on magnitudes, a few quotient bits per cycle; the
// quotient truncates toward zero.
// ============================================================================
`default_nettype none

module jastc_div (
   input  logic                                      clock,
   input  logic                                      reset,
   input  jastc_pkg::div_ctl_type                    ctl,
   input  logic signed [jastc_pkg::PROD_W-1:0]       dividend,
   input  logic signed [jastc_pkg::DIFF_W-1:0]       divisor,
   output logic signed [jastc_pkg::PROD_W-1:0]       quotient,
   output jastc_pkg::div_sts_type                    sts
);

   localparam int DVD_W = jastc_pkg::PROD_W;
   localparam int DVS_W = jastc_pkg::DIFF_W;
   localparam int CNT_W = $clog2(jastc_pkg::DIV_CYCLES + 1);

   logic [CNT_W-1:0] cnt_ff;
   logic             done_ff;
   logic [DVD_W-1:0] quo_ff;
   logic [DVS_W:0]   rem_ff;
   logic [DVS_W-1:0] dvs_ff;
   logic             neg_ff;

   logic [DVD_W-1:0] quo_in;
   logic [DVS_W:0]   rem_in;
   logic [DVD_W-1:0] dvd_mag;
   logic [DVS_W-1:0] dvs_mag;

   assign dvd_mag = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
   assign dvs_mag = divisor[DVS_W-1] ? DVS_W'(-divisor) : DVS_W'(divisor);

   // Shift one dividend bit into the remainder and subtract where it fits.
   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      for (int k = 0; k < jastc_pkg::DIV_STEPS; k++) begin
         rem_in = {rem_in[DVS_W-1:0], quo_in[DVD_W-1]};
         quo_in = {quo_in[DVD_W-2:0], 1'b0};
         if (rem_in >= {1'b0, dvs_ff}) begin
            rem_in    = rem_in - {1'b0, dvs_ff};
            quo_in[0] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= !ctl.start && (cnt_ff == CNT_W'(1));
         if (ctl.start) begin
            cnt_ff <= CNT_W'(jastc_pkg::DIV_CYCLES);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         quo_ff <= dvd_mag;
         rem_ff <= '0;
         dvs_ff <= dvs_mag;
         neg_ff <= dividend[DVD_W-1] ^ divisor[DVS_W-1];
      end else if (cnt_ff != '0) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
   assign sts.busy = (cnt_ff != '0);
   assign sts.done = done_ff;

endmodule

`default_nettype wire
